FILE: hdl/msvm_pkg.sv
// Shared types, constants and command/status structs of the voice mixer.
package msvm_pkg;

	localparam int MAX_SPEAKERS = 6;
	localparam int ACC_WIDTH    = 32;
	localparam int NUM_VOLS     = 6;

	localparam int SPK_W      = $clog2(MAX_SPEAKERS + 1);
	localparam int IDX_W      = $clog2(MAX_SPEAKERS);
	localparam int SAMPLE_W   = 16;
	localparam int VOL_W      = 8;
	localparam int MVOL_W     = 9;
	localparam int SPKCNT_W   = 3;
	localparam int RSIZE_W    = 17;
	localparam int SLOT_W     = 16;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int FRAC_SHIFT = 8;
	localparam int OPA_W      = ACC_WIDTH + 1;
	localparam int OPB_W      = MVOL_W + 1;
	localparam int PROD_W     = OPA_W + OPB_W;
	localparam int MOD_CNT_W  = $clog2(SLOT_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEAKER_COUNT   = 3'd0,
		CFG_OUTPUT_IS_16BIT = 3'd1,
		CFG_MASTER_VOLUME   = 3'd2,
		CFG_RING_SIZE       = 3'd3,
		CFG_RING_START      = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_first;
		logic signed [SAMPLE_W-1:0] sample_second;
		logic                       sample_is_16bit;
		logic                       source_stereo;
		logic [VOL_W-1:0]           vol_0;
		logic [VOL_W-1:0]           vol_1;
		logic [VOL_W-1:0]           vol_2;
		logic [VOL_W-1:0]           vol_3;
		logic [VOL_W-1:0]           vol_4;
		logic [VOL_W-1:0]           vol_5;
		logic                       end_of_frame;
	} in_req_t;

	typedef struct packed {
		logic [OUT_W-1:0]  out_value;
		logic [SLOT_W-1:0] out_slot;
		logic              out_last;
	} out_rsp_t;

	typedef struct packed {
		logic             load_item;
		logic             acc_mul;
		logic             out_mul;
		logic             out_load;
		logic             mod_start;
		logic             mod_step;
		logic             mod_load;
		logic             clear;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic acc_last;
		logic out_last;
		logic eof;
		logic slot_ok;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/msvm_datapath.sv
// Datapath: config registers, accumulators, shared multiplier, slot remainder, output register.
module msvm_datapath import msvm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_req_t               in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_rsp_t              out_data
);

	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
	localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-32768);
	localparam logic [RSIZE_W-1:0] RING_MAX = RSIZE_W'(1 << SLOT_W);

	logic [SPKCNT_W-1:0]        spk_cnt_q;
	logic                       out16_q;
	logic [MVOL_W-1:0]          mvol_q;
	logic [RSIZE_W-1:0]         rsize_q;
	logic [SLOT_W-1:0]          slot_q;
	in_req_t                    item_q;
	logic [ACC_WIDTH-1:0]       acc_q [MAX_SPEAKERS];
	logic signed [PROD_W-1:0]   prod_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic                       add_pend_s1;
	logic [SLOT_W-1:0]          div_q;
	logic [SLOT_W-1:0]          rem_q;
	logic                       out_valid_q;
	out_rsp_t                   out_q;

	logic [SPK_W-1:0]           n_spk;
	logic [SPK_W-1:0]           fan;
	logic [RSIZE_W-1:0]         size;
	logic [VOL_W-1:0]           vols [NUM_VOLS];
	logic [VOL_W-1:0]           vol;
	logic signed [SAMPLE_W-1:0] src;
	logic signed [SAMPLE_W-1:0] s16;
	logic [IDX_W-1:0]           rd_idx;
	logic [ACC_WIDTH-1:0]       acc_rd;
	logic signed [OPA_W-1:0]    op_a;
	logic signed [OPB_W-1:0]    op_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   shifted;
	logic [ACC_WIDTH-1:0]       contrib;
	logic [OUT_W-1:0]           sat;
	logic [OUT_W-1:0]           out_bits;
	logic [RSIZE_W-1:0]         slot_inc;
	logic [SLOT_W-1:0]          slot_nx;
	logic [RSIZE_W-1:0]         mod_t;
	logic [RSIZE_W-1:0]         mod_sub;
	logic [SLOT_W-1:0]          rem_nx;

	always_comb begin
		if (spk_cnt_q == '0) begin
			n_spk = SPK_W'(1);
		end else if (int'(spk_cnt_q) > MAX_SPEAKERS) begin
			n_spk = SPK_W'(MAX_SPEAKERS);
		end else begin
			n_spk = SPK_W'(spk_cnt_q);
		end
		if (item_q.source_stereo) begin
			fan = SPK_W'(2);
		end else if (n_spk == SPK_W'(4) || n_spk == SPK_W'(6)) begin
			fan = n_spk;
		end else begin
			fan = SPK_W'(2);
		end
		if (rsize_q == '0) begin
			size = RSIZE_W'(1);
		end else if (rsize_q > RING_MAX) begin
			size = RING_MAX;
		end else begin
			size = rsize_q;
		end
	end

	assign vols[0] = item_q.vol_0;
	assign vols[1] = item_q.vol_1;
	assign vols[2] = item_q.vol_2;
	assign vols[3] = item_q.vol_3;
	assign vols[4] = item_q.vol_4;
	assign vols[5] = item_q.vol_5;

	always_comb begin
		vol = '0;
		for (int i = 0; i < NUM_VOLS; i++) begin
			if (cmd.idx == IDX_W'(i)) begin
				vol = vols[i];
			end
		end
	end

	assign src = (item_q.source_stereo && cmd.idx == IDX_W'(1)) ?
		item_q.sample_second : item_q.sample_first;
	assign s16 = item_q.sample_is_16bit ? src : {{8{src[7]}}, src[7:0]};

	assign rd_idx = add_pend_s1 ? idx_s1 : cmd.idx;
	assign acc_rd = acc_q[rd_idx];

	always_comb begin
		if (cmd.out_mul) begin
			op_a = {acc_rd[ACC_WIDTH-1], acc_rd};
			op_b = {1'b0, mvol_q};
		end else begin
			op_a = OPA_W'(s16);
			op_b = OPB_W'(vol);
		end
	end

	assign prod    = op_a * op_b;
	assign shifted = prod_s1 >>> FRAC_SHIFT;
	assign contrib = item_q.sample_is_16bit ? shifted[ACC_WIDTH-1:0] : prod_s1[ACC_WIDTH-1:0];

	always_comb begin
		if (shifted > SAT_HI) begin
			sat = 16'h7fff;
		end else if (shifted < SAT_LO) begin
			sat = 16'h8000;
		end else begin
			sat = shifted[OUT_W-1:0];
		end
		out_bits = out16_q ? sat : {8'h00, sat[15:8] ^ 8'h80};
	end

	assign slot_inc = {1'b0, slot_q} + RSIZE_W'(1);
	assign slot_nx  = (slot_inc == size) ? '0 : slot_inc[SLOT_W-1:0];

	assign mod_t   = {rem_q, div_q[SLOT_W-1]};
	assign mod_sub = mod_t - size;
	assign rem_nx  = (mod_t >= size) ? mod_sub[SLOT_W-1:0] : mod_t[SLOT_W-1:0];

	assign sts.acc_last = (SPK_W'(cmd.idx) == fan - SPK_W'(1));
	assign sts.out_last = (SPK_W'(cmd.idx) == n_spk - SPK_W'(1));
	assign sts.eof      = item_q.end_of_frame;
	assign sts.slot_ok  = ({1'b0, slot_q} < size);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spk_cnt_q <= SPKCNT_W'(2);
			out16_q   <= 1'b1;
			mvol_q    <= MVOL_W'(256);
			rsize_q   <= RSIZE_W'(16384);
			slot_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPEAKER_COUNT:   spk_cnt_q <= cfg_data[SPKCNT_W-1:0];
				CFG_OUTPUT_IS_16BIT: out16_q   <= cfg_data[0];
				CFG_MASTER_VOLUME:   mvol_q    <= cfg_data[MVOL_W-1:0];
				CFG_RING_SIZE:       rsize_q   <= cfg_data[RSIZE_W-1:0];
				CFG_RING_START:      slot_q    <= cfg_data[SLOT_W-1:0];
				default: ;
			endcase
		end else if (cmd.mod_load) begin
			slot_q <= rem_q;
		end else if (cmd.out_load) begin
			slot_q <= slot_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SPEAKERS; i++) begin
				acc_q[i] <= '0;
			end
			add_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			add_pend_s1 <= cmd.acc_mul;
			if (cmd.clear) begin
				for (int i = 0; i < MAX_SPEAKERS; i++) begin
					acc_q[i] <= '0;
				end
			end else if (add_pend_s1) begin
				acc_q[idx_s1] <= acc_rd + contrib;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_data;
		end
		if (cmd.acc_mul || cmd.out_mul) begin
			prod_s1 <= prod;
			idx_s1  <= cmd.idx;
		end
		if (cmd.mod_start) begin
			div_q <= slot_q;
			rem_q <= '0;
		end else if (cmd.mod_step) begin
			div_q <= {div_q[SLOT_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
		if (cmd.out_load) begin
			out_q.out_value <= out_bits;
			out_q.out_slot  <= slot_q;
			out_q.out_last  <= sts.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("output register loaded while occupied");
	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		add_pend_s1 |-> !cmd.out_mul)
		else $error("accumulator read port claimed twice");
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> acc_q[0] == '0)
		else $error("accumulator not cleared after frame");

endmodule

FILE: hdl/msvm_ctrl.sv
// Controller: sequences accumulation, slot reduction and per-speaker output.
module msvm_ctrl import msvm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ACC   = 7'b0000010,
		ST_ADD   = 7'b0000100,
		ST_MOD   = 7'b0001000,
		ST_MODLD = 7'b0010000,
		ST_OMUL  = 7'b0100000,
		ST_OFMT  = 7'b1000000
	} state_t;

	state_t               state_q, state_n;
	logic [IDX_W-1:0]     idx_q, idx_n;
	logic [MOD_CNT_W-1:0] cnt_q, cnt_n;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_n = state_q;
		idx_n   = idx_q;
		cnt_n   = cnt_q;
		cmd     = '0;
		cmd.idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					idx_n         = '0;
					state_n       = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_mul = 1'b1;
				if (sts.acc_last) begin
					state_n = ST_ADD;
				end else begin
					idx_n = idx_q + IDX_W'(1);
				end
			end
			ST_ADD: begin
				idx_n = '0;
				if (!sts.eof) begin
					state_n = ST_IDLE;
				end else if (sts.slot_ok) begin
					state_n = ST_OMUL;
				end else begin
					cmd.mod_start = 1'b1;
					cnt_n         = '0;
					state_n       = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (cnt_q == MOD_CNT_W'(SLOT_W - 1)) begin
					state_n = ST_MODLD;
				end else begin
					cnt_n = cnt_q + MOD_CNT_W'(1);
				end
			end
			ST_MODLD: begin
				cmd.mod_load = 1'b1;
				idx_n        = '0;
				state_n      = ST_OMUL;
			end
			ST_OMUL: begin
				cmd.out_mul = 1'b1;
				state_n     = ST_OFMT;
			end
			ST_OFMT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.out_last) begin
						cmd.clear = 1'b1;
						state_n   = ST_IDLE;
					end else begin
						idx_n   = idx_q + IDX_W'(1);
						state_n = ST_OMUL;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
		end
	end

	a_one_mul: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.acc_mul && cmd.out_mul))
		else $error("multiplier issued twice");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && sts.out_last |-> cmd.clear)
		else $error("frame ended without clearing accumulators");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(idx_q) < MAX_SPEAKERS)
		else $error("speaker index out of range");

endmodule

FILE: hdl/multi_speaker_voice_mixer_top.sv
// Top level of the multi-speaker voice mixer: controller plus datapath.
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | in_data    (in_req_t)
//  out     | out_valid / out_ready | out_data   (out_rsp_t)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request feeds fan = 2, 4 or 6 speakers, one per cycle through the single
// shared multiplier. At end of frame each output speaker gets a multiply and a
// format step; a write slot at or beyond the ring size is first reduced by a
// bit-serial remainder. Output waits on out_ready; the output register lets the
// next request enter while the last sample is pending. Reset restores register
// defaults and clears the accumulators at once. cfg_ready is always high.
module multi_speaker_voice_mixer_top import msvm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_req_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_rsp_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	msvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msvm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

FILE: tb/multi_speaker_voice_mixer_checker.sv
// Checker for the voice mixer: mixes accepted voice requests and compares speaker samples.
module multi_speaker_voice_mixer_checker import msvm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_req_t               in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_rsp_t              out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    checked,
	output int                    pending
);

	logic signed [ACC_WIDTH-1:0] mix_acc [MAX_SPEAKERS];
	logic [SLOT_W-1:0]           next_slot;
	logic [SPKCNT_W-1:0]         spk_cnt;
	logic                        wide_out;
	logic [MVOL_W-1:0]           master_vol;
	logic [RSIZE_W-1:0]          ring_len;
	out_rsp_t                    expected_samples [$];
	int                          mismatches;
	int                          samples_seen;

	assign errors  = mismatches;
	assign checked = samples_seen;

	task automatic add_voice(input int spk, input longint smp, input longint vol, input bit wide);
		longint part;
		part = wide ? ((smp * vol) >>> FRAC_SHIFT) : smp * vol;
		mix_acc[spk] = mix_acc[spk] + part[ACC_WIDTH-1:0];
	endtask

	task automatic mix_voice(input in_req_t r);
		longint   s0, s1, scaled, byte_val;
		longint   vol [NUM_VOLS];
		int       n, fan, ring, slot;
		out_rsp_t res;
		if (r.sample_is_16bit) begin
			s0 = longint'($signed(r.sample_first));
			s1 = longint'($signed(r.sample_second));
		end else begin
			s0 = longint'($signed(r.sample_first[7:0]));
			s1 = longint'($signed(r.sample_second[7:0]));
		end
		vol[0] = longint'(r.vol_0);
		vol[1] = longint'(r.vol_1);
		vol[2] = longint'(r.vol_2);
		vol[3] = longint'(r.vol_3);
		vol[4] = longint'(r.vol_4);
		vol[5] = longint'(r.vol_5);
		n = int'(spk_cnt);
		if (n < 1) n = 1;
		if (n > MAX_SPEAKERS) n = MAX_SPEAKERS;
		if (r.source_stereo) begin
			add_voice(0, s0, vol[0], r.sample_is_16bit);
			add_voice(1, s1, vol[1], r.sample_is_16bit);
		end else begin
			fan = (n == 4 || n == 6) ? n : 2;
			for (int i = 0; i < fan; i++)
				add_voice(i, s0, vol[i], r.sample_is_16bit);
		end
		if (!r.end_of_frame) return;
		ring = int'(ring_len);
		if (ring < 1) ring = 1;
		if (ring > 65536) ring = 65536;
		slot = int'(next_slot) % ring;
		for (int i = 0; i < n; i++) begin
			scaled = (longint'(mix_acc[i]) * longint'(master_vol)) >>> FRAC_SHIFT;
			if (scaled > 32767) scaled = 32767;
			else if (scaled < -32768) scaled = -32768;
			if (wide_out) begin
				res.out_value = scaled[15:0];
			end else begin
				byte_val = (scaled >>> 8) + 128;
				res.out_value = {8'h00, byte_val[7:0]};
			end
			res.out_slot = slot[SLOT_W-1:0];
			res.out_last = (i == n - 1);
			expected_samples.push_back(res);
			slot++;
			if (slot >= ring) slot = 0;
		end
		next_slot = slot[SLOT_W-1:0];
		for (int i = 0; i < MAX_SPEAKERS; i++)
			mix_acc[i] = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_rsp_t exp_s;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SPEAKERS; i++)
				mix_acc[i] = '0;
			spk_cnt      = 3'd2;
			wide_out     = 1'b1;
			master_vol   = 9'd256;
			ring_len     = 17'd16384;
			next_slot    = '0;
			mismatches   = 0;
			samples_seen = 0;
			expected_samples.delete();
			pending      = 0;
		end else begin
			if (out_valid && out_ready) begin
				samples_seen++;
				if (expected_samples.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected speaker sample: value %h slot %h last %b",
							out_data.out_value, out_data.out_slot, out_data.out_last);
					mismatches++;
				end else begin
					exp_s = expected_samples.pop_front();
					if (exp_s.out_value !== out_data.out_value ||
						exp_s.out_slot !== out_data.out_slot ||
						exp_s.out_last !== out_data.out_last) begin
						if (mismatches < 10)
							$display({"speaker sample mismatch: expected value %h slot %h",
								" last %b, got value %h slot %h last %b"},
								exp_s.out_value, exp_s.out_slot, exp_s.out_last,
								out_data.out_value, out_data.out_slot, out_data.out_last);
						mismatches++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_SPEAKER_COUNT:   spk_cnt = cfg_data[SPKCNT_W-1:0];
					CFG_OUTPUT_IS_16BIT: wide_out = cfg_data[0];
					CFG_MASTER_VOLUME:   master_vol = cfg_data[MVOL_W-1:0];
					CFG_RING_SIZE:       ring_len = cfg_data[RSIZE_W-1:0];
					CFG_RING_START:      next_slot = cfg_data[SLOT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				mix_voice(in_data);
			pending = expected_samples.size();
		end
	end

endmodule

FILE: tb/multi_speaker_voice_mixer_top_tb.sv
// Testbench top for the voice mixer: clock, reset, request stimulus and verdict.
module multi_speaker_voice_mixer_top_tb;
	import msvm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 50;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_req_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_rsp_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int checked;
	int pending;
	int voices_sent;
	int frames_sent;
	int stall_left;
	int quiet_cycles;
	bit calm;

	multi_speaker_voice_mixer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	multi_speaker_voice_mixer_checker mix_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.checked   (checked),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// stall the sample sink in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready = 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			out_ready = 1'b0;
		end else begin
			out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("multi_speaker_voice_mixer_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_mode(input int spk, input int wide, input int mvol, input int rlen,
		input int rstart);
		write_reg(CFG_SPEAKER_COUNT, CFG_DATA_W'(spk));
		write_reg(CFG_OUTPUT_IS_16BIT, CFG_DATA_W'(wide));
		write_reg(CFG_MASTER_VOLUME, CFG_DATA_W'(mvol));
		write_reg(CFG_RING_SIZE, CFG_DATA_W'(rlen));
		write_reg(CFG_RING_START, CFG_DATA_W'(rstart));
	endtask

	// drain pending samples, then let the mixer go idle
	task automatic settle();
		in_valid = 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_voice(input in_req_t r);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		voices_sent++;
		if (r.end_of_frame) frames_sent++;
	endtask

	function automatic in_req_t voice(input int s0, input int s1, input int wide,
		input int stereo, input int vol, input int eof);
		in_req_t r;
		r.sample_first    = s0[15:0];
		r.sample_second   = s1[15:0];
		r.sample_is_16bit = wide[0];
		r.source_stereo   = stereo[0];
		r.vol_0           = vol[7:0];
		r.vol_1           = vol[7:0];
		r.vol_2           = vol[7:0];
		r.vol_3           = vol[7:0];
		r.vol_4           = vol[7:0];
		r.vol_5           = vol[7:0];
		r.end_of_frame    = eof[0];
		return r;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 8'hff;
			1: return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic in_req_t random_voice(input bit eof);
		in_req_t r;
		r.sample_first    = pick_sample();
		r.sample_second   = pick_sample();
		r.sample_is_16bit = 1'($urandom_range(0, 1));
		r.source_stereo   = ($urandom_range(0, 2) == 0);
		r.vol_0           = pick_gain();
		r.vol_1           = pick_gain();
		r.vol_2           = pick_gain();
		r.vol_3           = pick_gain();
		r.vol_4           = pick_gain();
		r.vol_5           = pick_gain();
		r.end_of_frame    = eof;
		return r;
	endfunction

	task automatic random_frames(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
			for (int j = 0; j < len; j++)
				send_voice(random_voice(j == len - 1));
			sent += len;
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_ready  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_SPEAKER_COUNT;
		cfg_data   = '0;
		stall_left = 0;
		quiet_cycles = 0;
		voices_sent = 0;
		frames_sent = 0;
		calm       = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_voice(voice(32767, 0, 1, 0, 255, 1));
		send_voice(voice(-32768, 0, 1, 0, 255, 1));
		send_voice(voice(16'h1280, 0, 0, 0, 255, 1));
		send_voice(voice(16'h7f7f, 0, 0, 0, 1, 1));
		send_voice(voice(32767, -32768, 1, 1, 255, 1));
		send_voice(voice(-1, 127, 0, 1, 255, 1));
		send_voice(voice(32767, 32767, 1, 0, 255, 0));
		send_voice(voice(32767, 32767, 1, 0, 255, 0));
		send_voice(voice(32767, 32767, 1, 0, 255, 1));
		send_voice(voice(-32768, -32768, 1, 0, 255, 0));
		send_voice(voice(-32768, -32768, 1, 0, 255, 0));
		send_voice(voice(-32768, -32768, 1, 0, 255, 1));
		send_voice(voice(12345, -12345, 1, 0, 0, 1));
		send_voice(voice(0, 0, 0, 0, 0, 1));
		send_voice(voice(-1, 0, 1, 0, 255, 1));
		random_frames(20);
		settle();

		set_mode(6, 0, 256, 65536, 65530);
		send_voice(voice(16'h0080, 0, 0, 0, 255, 1));
		send_voice(voice(127, -128, 0, 1, 255, 1));
		send_voice(voice(32767, 0, 1, 0, 255, 1));
		random_frames(20);
		settle();

		set_mode(4, 1, 511, 1, 0);
		random_frames(20);
		settle();

		set_mode(1, 0, 0, 5, 100);
		random_frames(15);
		settle();

		set_mode(0, 1, 1, 0, 65535);
		random_frames(15);
		settle();

		set_mode(7, 1, 256, 131071, 65535);
		random_frames(20);
		settle();

		set_mode(3, 0, 300, 7, 3);
		random_frames(20);
		settle();

		calm = 1'b1;
		set_mode(5, 1, 128, 16384, 12345);
		random_frames(30);
		settle();

		$display("covered %0d voice requests in %0d frames, %0d speaker samples checked",
			voices_sent, frames_sent, checked);
		$display({"speaker counts 0 to 7, 8- and 16-bit output, master volume 0 to 511,",
			" ring sizes 0 to 131071"});
		if (errors == 0 && pending == 0) begin
			$display("multi_speaker_voice_mixer_top regression: pass");
		end else begin
			$display("multi_speaker_voice_mixer_top regression: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/msvm_pkg.sv
hdl/msvm_datapath.sv
hdl/msvm_ctrl.sv
hdl/multi_speaker_voice_mixer_top.sv
tb/multi_speaker_voice_mixer_checker.sv
tb/multi_speaker_voice_mixer_top_tb.sv
